### rtl/core/grid_feature_spacing_filter_top_defines.svh
// Assertion macros used by the RTL top level.
`ifndef GRID_FEATURE_SPACING_FILTER_TOP_DEFINES_SVH
`define GRID_FEATURE_SPACING_FILTER_TOP_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define GFSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that a condition never holds.
`define GFSF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### rtl/core/gfsf_pkg.sv
package gfsf_pkg;

  localparam int unsigned MaxCells  = 64;
  localparam int unsigned CellDepth = 16;
  localparam int unsigned CellW     = $clog2(MaxCells);
  localparam int unsigned SlotW     = $clog2(CellDepth);
  localparam int unsigned CntW      = $clog2(CellDepth + 1);
  localparam int unsigned PtAddrW   = CellW + SlotW;

  localparam logic [1:0] ActClear  = 2'd0;
  localparam logic [1:0] ActRef    = 2'd1;
  localparam logic [1:0] ActCand   = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StAccepted = 3'd1;
  localparam logic [2:0] StOutside  = 3'd2;
  localparam logic [2:0] StEdge     = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StClose    = 3'd5;
  localparam logic [2:0] StOverflow = 3'd6;

  localparam logic [2:0] RegImageCols = 3'd0;
  localparam logic [2:0] RegImageRows = 3'd1;
  localparam logic [2:0] RegBlockW    = 3'd2;
  localparam logic [2:0] RegBlockH    = 3'd3;
  localparam logic [2:0] RegGridCols  = 3'd4;
  localparam logic [2:0] RegGridRows  = 3'd5;
  localparam logic [2:0] RegMinDist   = 3'd6;
  localparam logic [2:0] RegMaxFeats  = 3'd7;

  typedef struct packed {
    logic [11:0] image_cols;
    logic [11:0] image_rows;
    logic [11:0] block_w;
    logic [11:0] block_h;
    logic [6:0]  grid_cols;
    logic [6:0]  grid_rows;
    logic [7:0]  min_dist;
    logic [9:0]  max_feats;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic geo;
    logic div_step;
    logic locate;
    logic fetch;
    logic check;
    logic scan_issue;
    logic scan_cmp;
    logic store;
    logic clear;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic       outside;
    logic       no_div;
    logic       div_done;
    logic       reject;
    logic       scan_more;
    logic       close;
    logic [1:0] action;
  } sts_t;

endpackage

### rtl/core/gfsf_ram.sv
module gfsf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/gfsf_ctrl.sv
module gfsf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  gfsf_pkg::sts_t  sts_i,
  output gfsf_pkg::cmd_t  cmd_o
);
  import gfsf_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SGeo   = 4'd1;
  localparam logic [3:0] SDiv   = 4'd2;
  localparam logic [3:0] SLoc   = 4'd3;
  localparam logic [3:0] SFetch = 4'd4;
  localparam logic [3:0] SCheck = 4'd5;
  localparam logic [3:0] SIssue = 4'd6;
  localparam logic [3:0] SCmp   = 4'd7;
  localparam logic [3:0] SStore = 4'd8;
  localparam logic [3:0] SOut   = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SGeo;
        end
      end
      SGeo: begin
        cmd_o.geo = 1'b1;
        if (sts_i.action == ActClear) begin
          cmd_o.clear = 1'b1;
          state_d     = SOut;
        end else if (sts_i.action != ActRef && sts_i.action != ActCand) begin
          cmd_o.finish = 1'b1;
          state_d      = SOut;
        end else begin
          state_d = SDiv;
        end
      end
      SDiv: begin
        if (sts_i.no_div) begin
          cmd_o.finish = 1'b1;
          state_d      = SOut;
        end else begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_done) begin
            state_d = SLoc;
          end
        end
      end
      SLoc: begin
        cmd_o.locate = 1'b1;
        state_d      = SFetch;
      end
      SFetch: begin
        if (sts_i.outside) begin
          cmd_o.finish = 1'b1;
          state_d      = SOut;
        end else begin
          cmd_o.fetch = 1'b1;
          state_d     = SCheck;
        end
      end
      SCheck: begin
        cmd_o.check = 1'b1;
        if (sts_i.reject) begin
          state_d = SOut;
        end else if (sts_i.action == ActCand) begin
          state_d = SIssue;
        end else begin
          state_d = SStore;
        end
      end
      SIssue: begin
        if (sts_i.scan_more) begin
          cmd_o.scan_issue = 1'b1;
          state_d          = SCmp;
        end else begin
          state_d = SStore;
        end
      end
      SCmp: begin
        cmd_o.scan_cmp = 1'b1;
        if (sts_i.close) begin
          state_d = SOut;
        end else begin
          state_d = SIssue;
        end
      end
      SStore: begin
        cmd_o.store = 1'b1;
        state_d     = SOut;
      end
      SOut: begin
        if (out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/gfsf_dp.sv
module gfsf_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gfsf_pkg::cfg_t  cfg_i,
  input  logic [1:0]      action_i,
  input  logic [15:0]     pos_x_i,
  input  logic [15:0]     pos_y_i,
  input  gfsf_pkg::cmd_t  cmd_i,
  output gfsf_pkg::sts_t  sts_o,
  output logic [2:0]      status_o,
  output logic            accepted_o,
  output logic [5:0]      cell_index_o,
  output logic [4:0]      cell_fill_o
);
  import gfsf_pkg::*;

  logic [1:0]  act_q;
  logic [15:0] px_q, py_q;
  logic        out_q;
  logic [16:0] remx_q, remy_q;
  logic [15:0] colq_q, rowq_q;
  logic [4:0]  dcnt_q;
  logic        div_done_q;
  logic [CellW-1:0] idx_q;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  slot_q;
  logic [2:0]  status_q;
  logic        acc_q;
  logic [5:0]  oidx_q;
  logic [4:0]  ofill_q;
  logic [MaxCells-1:0] cnt_vld_q;

  logic [18:0] usedx, usedy;
  logic [17:0] offx_w, offy_w;
  logic [16:0] bw16, bh16;
  logic [16:0] tx, ty;
  logic [16:0] rx_sh, ry_sh;
  logic [21:0] lin_idx;
  logic [31:0] rd_data;
  logic [CntW-1:0] cnt_rd;
  logic        ram_we;
  logic [PtAddrW-1:0] waddr, raddr;
  logic [15:0] dx, dy;
  logic [32:0] dist2;
  logic [24:0] md2;
  logic [16:0] md16;
  logic        edge_hit;
  logic [11:0] cnt4;
  logic [11:0] lim3;

  assign usedx  = 19'(cfg_i.grid_cols) * 19'(cfg_i.block_w);
  assign usedy  = 19'(cfg_i.grid_rows) * 19'(cfg_i.block_h);
  assign offx_w = (usedx >= 19'(cfg_i.image_cols)) ? '0 : 18'((19'(cfg_i.image_cols) - usedx) >> 1);
  assign offy_w = (usedy >= 19'(cfg_i.image_rows)) ? '0 : 18'((19'(cfg_i.image_rows) - usedy) >> 1);
  assign bw16   = {1'b0, cfg_i.block_w, 4'b0};
  assign bh16   = {1'b0, cfg_i.block_h, 4'b0};
  assign md16   = {5'b0, cfg_i.min_dist, 4'b0};
  assign md2    = 25'(md16[12:0]) * 25'(md16[12:0]);

  assign rx_sh = {remx_q[15:0], 1'b0} | 17'(colq_q[15]);
  assign ry_sh = {remy_q[15:0], 1'b0} | 17'(rowq_q[15]);
  assign tx    = {remx_q[15:0], colq_q[15]};
  assign ty    = {remy_q[15:0], rowq_q[15]};

  assign lin_idx = 22'(rowq_q) * 22'(cfg_i.grid_cols) + 22'(colq_q);

  assign edge_hit = (remx_q < md16) || (bw16 - remx_q < md16) ||
                    (remy_q < md16) || (bh16 - remy_q < md16);
  assign cnt4 = {5'b0, cnt_q, 2'b0};
  assign lim3 = 12'(cfg_i.max_feats) + {1'b0, cfg_i.max_feats, 1'b0};

  assign dx    = (rd_data[15:0] > px_q) ? rd_data[15:0] - px_q : px_q - rd_data[15:0];
  assign dy    = (rd_data[31:16] > py_q) ? rd_data[31:16] - py_q : py_q - rd_data[31:16];
  assign dist2 = 33'(32'(dx) * 32'(dx)) + 33'(32'(dy) * 32'(dy));

  assign ram_we = cmd_i.store && (cnt_q < CntW'(CellDepth));
  assign waddr  = {idx_q, cnt_q[SlotW-1:0]};
  assign raddr  = {idx_q, slot_q[SlotW-1:0]};

  gfsf_ram #(.Width(32), .Depth(MaxCells * CellDepth)) u_pts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({py_q, px_q}),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // The count of the located cell is read while the cell index settles, so it
  // is ready in the fetch cycle.
  gfsf_ram #(.Width(CntW), .Depth(MaxCells)) u_cnt (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (cnt_q + CntW'(1)),
    .raddr_i (lin_idx[CellW-1:0]),
    .rdata_o (cnt_rd)
  );

  assign sts_o.action    = act_q;
  assign sts_o.outside   = out_q;
  assign sts_o.no_div    = out_q;
  assign sts_o.div_done  = div_done_q;
  assign sts_o.reject    = edge_hit && (act_q == ActCand) ||
                           (act_q == ActCand) && (cnt4 >= lim3);
  assign sts_o.scan_more = (slot_q < cnt_q);
  assign sts_o.close     = (dist2 <= 33'(md2));

  assign status_o     = status_q;
  assign accepted_o   = acc_q;
  assign cell_index_o = oidx_q;
  assign cell_fill_o  = ofill_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
    end
    if (cmd_i.geo) begin
      out_q      <= (cfg_i.block_w == '0) || (cfg_i.block_h == '0) ||
                    (cfg_i.grid_cols == '0) || (cfg_i.grid_rows == '0) ||
                    (17'(px_q) <= {offx_w[12:0], 4'b0}) ||
                    (17'(py_q) <= {offy_w[12:0], 4'b0}) ||
                    (17'(px_q) >= {1'b0, cfg_i.image_cols - offx_w[11:0], 4'b0}) ||
                    (17'(py_q) >= {1'b0, cfg_i.image_rows - offy_w[11:0], 4'b0});
      remx_q     <= '0;
      remy_q     <= '0;
      colq_q     <= px_q - {offx_w[11:0], 4'b0};
      rowq_q     <= py_q - {offy_w[11:0], 4'b0};
      dcnt_q     <= '0;
      div_done_q <= 1'b0;
    end
    if (cmd_i.div_step) begin
      if (tx >= bw16) begin
        remx_q <= rx_sh - bw16;
        colq_q <= {colq_q[14:0], 1'b1};
      end else begin
        remx_q <= rx_sh;
        colq_q <= {colq_q[14:0], 1'b0};
      end
      if (ty >= bh16) begin
        remy_q <= ry_sh - bh16;
        rowq_q <= {rowq_q[14:0], 1'b1};
      end else begin
        remy_q <= ry_sh;
        rowq_q <= {rowq_q[14:0], 1'b0};
      end
      dcnt_q     <= dcnt_q + 5'd1;
      div_done_q <= (dcnt_q == 5'd14);
    end
    if (cmd_i.locate) begin
      idx_q <= lin_idx[CellW-1:0];
      if ((colq_q >= 16'(cfg_i.grid_cols)) || (rowq_q >= 16'(cfg_i.grid_rows)) ||
          (lin_idx >= 22'(MaxCells))) begin
        out_q <= 1'b1;
      end
    end
    if (cmd_i.fetch) begin
      cnt_q  <= cnt_vld_q[idx_q] ? cnt_rd : '0;
      slot_q <= '0;
    end
    if (cmd_i.scan_issue) begin
      slot_q <= slot_q + CntW'(1);
    end
    if (cmd_i.finish) begin
      status_q <= out_q && (act_q == ActRef || act_q == ActCand) ? StOutside : StOk;
      acc_q    <= 1'b0;
      oidx_q   <= '0;
      ofill_q  <= '0;
    end
    if (cmd_i.clear) begin
      status_q <= StOk;
      acc_q    <= 1'b0;
      oidx_q   <= '0;
      ofill_q  <= '0;
    end
    if (cmd_i.check) begin
      oidx_q  <= 6'(idx_q);
      ofill_q <= 5'(cnt_q);
      acc_q   <= 1'b0;
      status_q <= edge_hit ? StEdge : StFull;
    end
    if (cmd_i.scan_cmp && sts_o.close) begin
      status_q <= StClose;
    end
    if (cmd_i.store) begin
      if (cnt_q >= CntW'(CellDepth)) begin
        status_q <= StOverflow;
        acc_q    <= 1'b0;
      end else begin
        status_q <= (act_q == ActCand) ? StAccepted : StOk;
        acc_q    <= (act_q == ActCand);
        ofill_q  <= 5'(cnt_q + CntW'(1));
      end
    end
  end

  // The scan compares the slot fetched in the issue cycle, so the read address
  // steps one ahead of the compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_vld_q <= '0;
    end else if (ram_we) begin
      cnt_vld_q[idx_q] <= 1'b1;
    end
  end

endmodule

### rtl/core/grid_feature_spacing_filter_top.sv
// A clear or an unused action goes straight to the result; a reference point inside
// the grid is located and stored; a candidate may be rejected or walks its cell first.
// A 16-step divider locates the cell; the walk alternates an issue and a compare per stored point.
// One word is in flight at a time; the next is taken in the cycle after the result leaves.
// Reset is asynchronous, active low: control state, configuration and cell-valid flags
// go to their reset values and every cell reads as empty; the point and count RAMs are not cleared.
`include "grid_feature_spacing_filter_top_defines.svh"
module grid_feature_spacing_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        accepted_o,
  output logic [5:0]  cell_index_o,
  output logic [4:0]  cell_fill_o
);
  import gfsf_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_cols <= 12'd640;
      cfg_q.image_rows <= 12'd480;
      cfg_q.block_w    <= 12'd160;
      cfg_q.block_h    <= 12'd120;
      cfg_q.grid_cols  <= 7'd4;
      cfg_q.grid_rows  <= 7'd4;
      cfg_q.min_dist   <= 8'd15;
      cfg_q.max_feats  <= 10'd12;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegImageCols: cfg_q.image_cols <= cfg_data_i;
        RegImageRows: cfg_q.image_rows <= cfg_data_i;
        RegBlockW:    cfg_q.block_w    <= cfg_data_i;
        RegBlockH:    cfg_q.block_h    <= cfg_data_i;
        RegGridCols:  cfg_q.grid_cols  <= cfg_data_i[6:0];
        RegGridRows:  cfg_q.grid_rows  <= cfg_data_i[6:0];
        RegMinDist:   cfg_q.min_dist   <= cfg_data_i[7:0];
        RegMaxFeats:  cfg_q.max_feats  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  gfsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gfsf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .action_i     (action_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .status_o     (status_o),
    .accepted_o   (accepted_o),
    .cell_index_o (cell_index_o),
    .cell_fill_o  (cell_fill_o)
  );

  `GFSF_ASSERT_NEVER(a_rdy_and_out, clk_i, rst_ni, in_ready_o && out_valid_o, "ready while result held")
  `GFSF_ASSERT_IMP(a_acc_status, clk_i, rst_ni, out_valid_o && accepted_o, status_o == StAccepted, "accepted flag mismatch")
  `GFSF_ASSERT_NEVER(a_store_scan, clk_i, rst_ni, cmd.store && cmd.scan_cmp, "store during scan")

endmodule
